### rtl/oal_pkg.sv
// Package for the ordered array list engine: command and status codes,
// controller state, datapath op codes, and the control/status structs between control and datapath.
// No dependencies.
package oal_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CMD_W          = 3;
    localparam int STATUS_W       = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET    = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_CHANGE = 3'd3,
        CMD_LOCATE = 3'd4,
        CMD_CLEAR  = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE     = 3'd0,
        STAT_BADPOS   = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_EMPTY    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_GET_RD,
        ST_GET_CAP,
        ST_INS_SHIFT,
        ST_INS_LAST,
        ST_INS_PUT,
        ST_DEL_SHIFT,
        ST_DEL_LAST,
        ST_LOC_SCAN,
        ST_LOC_LAST,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_LOAD_POSM1,
        PTR_LOAD_CNTM1,
        PTR_LOAD_ZERO,
        PTR_INC,
        PTR_DEC
    } ptr_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_VAL_POS,
        WR_SHIFT_UP,
        WR_SHIFT_DN
    } wr_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_op_t;

    typedef struct packed {
        logic    ld;
        ptr_op_t ptr_op;
        logic    rd;
        wr_sel_t wr;
        cnt_op_t cnt_op;
        logic    res_status_ld;
        status_t res_status;
        logic    cap_data;
        logic    set_found;
        logic    out_ld;
    } ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             bad_get;
        logic             bad_ins;
        logic             full;
        logic             empty;
        logic             append;
        logic             ptr_last;
        logic             ptr_at_pos;
        logic             tag_at_pos;
        logic             pend;
        logic             match;
        logic             out_free;
    } sts_t;

endpackage

### rtl/oal_if.sv
// Handshake channels of the ordered array list engine: command in, result out.
// Depends on oal_pkg.
interface oal_cmd_if #(
    parameter int POS_W  = 7,
    parameter int DATA_W = oal_pkg::DATA_WIDTH_DEF
);
    logic                     valid;
    logic                     ready;
    logic [oal_pkg::CMD_W-1:0] command;
    logic [POS_W-1:0]         position;
    logic [DATA_W-1:0]        value;

    modport source (output valid, command, position, value, input ready);
    modport sink   (input valid, command, position, value, output ready);
endinterface

interface oal_rsp_if #(
    parameter int POS_W  = 7,
    parameter int DATA_W = oal_pkg::DATA_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic [oal_pkg::STATUS_W-1:0] status;
    logic [DATA_W-1:0]           data;
    logic [POS_W-1:0]            found_position;
    logic [POS_W-1:0]            count;
    logic                        is_empty;

    modport source (output valid, status, data, found_position, count, is_empty,
                    input ready);
    modport sink   (input valid, status, data, found_position, count, is_empty,
                    output ready);
endinterface

### rtl/oal_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module oal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### rtl/oal_dp.sv
// Datapath of the ordered array list engine: entry memory, length, walk pointer,
// result staging and output register. Depends on oal_pkg and oal_ram.
module oal_dp #(
    parameter int CAPACITY   = oal_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = oal_pkg::DATA_WIDTH_DEF,
    parameter int POS_W      = $clog2(CAPACITY + 2)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  oal_pkg::ctl_t               ctl,
    output oal_pkg::sts_t               sts,
    input  logic [oal_pkg::CMD_W-1:0]   command,
    input  logic [POS_W-1:0]            position,
    input  logic [DATA_WIDTH-1:0]       value,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [oal_pkg::STATUS_W-1:0] status,
    output logic [DATA_WIDTH-1:0]       data,
    output logic [POS_W-1:0]            found_position,
    output logic [POS_W-1:0]            count,
    output logic                        is_empty
);
    localparam int ADDR_W = $clog2(CAPACITY);

    logic [oal_pkg::CMD_W-1:0]    cmd_reg;
    logic [POS_W-1:0]             pos_reg;
    logic [DATA_WIDTH-1:0]        val_reg;
    logic [POS_W-1:0]             count_reg, count_next;
    logic [ADDR_W-1:0]            ptr_reg, ptr_next;
    logic [ADDR_W-1:0]            tag_reg;
    logic                         pend_reg;
    logic [oal_pkg::STATUS_W-1:0] res_status_reg;
    logic [DATA_WIDTH-1:0]        res_data_reg;
    logic [POS_W-1:0]             res_found_reg;
    logic                         out_valid_reg;
    logic [oal_pkg::STATUS_W-1:0] out_status_reg;
    logic [DATA_WIDTH-1:0]        out_data_reg;
    logic [POS_W-1:0]             out_found_reg;
    logic [POS_W-1:0]             out_count_reg;
    logic                         out_empty_reg;

    logic [POS_W-1:0]      pos_m1, count_m1;
    logic [ADDR_W-1:0]     pos_addr, cnt_addr;
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [DATA_WIDTH-1:0] rdata;

    assign pos_m1   = pos_reg - POS_W'(1);
    assign count_m1 = count_reg - POS_W'(1);
    assign pos_addr = pos_m1[ADDR_W-1:0];
    assign cnt_addr = count_m1[ADDR_W-1:0];

    always_comb
    begin
        we    = 1'b0;
        waddr = pos_addr;
        wdata = val_reg;
        case (ctl.wr)
            oal_pkg::WR_VAL_POS:
            begin
                we = 1'b1;
            end
            oal_pkg::WR_SHIFT_UP:
            begin
                we    = 1'b1;
                waddr = tag_reg + ADDR_W'(1);
                wdata = rdata;
            end
            oal_pkg::WR_SHIFT_DN:
            begin
                we    = 1'b1;
                waddr = tag_reg - ADDR_W'(1);
                wdata = rdata;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    oal_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ctl.rd),
        .raddr (ptr_reg),
        .rdata (rdata)
    );

    always_comb
    begin
        case (ctl.ptr_op)
            oal_pkg::PTR_LOAD_POSM1: ptr_next = pos_addr;
            oal_pkg::PTR_LOAD_CNTM1: ptr_next = cnt_addr;
            oal_pkg::PTR_LOAD_ZERO:  ptr_next = '0;
            oal_pkg::PTR_INC:        ptr_next = ptr_reg + ADDR_W'(1);
            oal_pkg::PTR_DEC:        ptr_next = ptr_reg - ADDR_W'(1);
            default:                 ptr_next = ptr_reg;
        endcase
        case (ctl.cnt_op)
            oal_pkg::CNT_INC: count_next = count_reg + POS_W'(1);
            oal_pkg::CNT_DEC: count_next = count_m1;
            oal_pkg::CNT_CLR: count_next = '0;
            default:          count_next = count_reg;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= ctl.rd;
            if (ctl.out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (ctl.rd)
        begin
            tag_reg <= ptr_reg;
        end
        if (ctl.ld)
        begin
            cmd_reg        <= command;
            pos_reg        <= position;
            val_reg        <= value;
            res_status_reg <= oal_pkg::STAT_DONE;
            res_data_reg   <= '0;
            res_found_reg  <= '0;
        end
        else
        begin
            if (ctl.res_status_ld)
            begin
                res_status_reg <= ctl.res_status;
            end
            if (ctl.cap_data)
            begin
                res_data_reg <= rdata;
            end
            if (ctl.set_found)
            begin
                res_found_reg <= POS_W'(tag_reg) + POS_W'(1);
            end
        end
        if (ctl.out_ld)
        begin
            out_status_reg <= res_status_reg;
            out_data_reg   <= res_data_reg;
            out_found_reg  <= res_found_reg;
            out_count_reg  <= count_reg;
            out_empty_reg  <= (count_reg == '0);
        end
    end

    always_comb
    begin
        sts.cmd        = cmd_reg;
        sts.bad_get    = (pos_reg == '0) || (pos_reg > count_reg);
        sts.bad_ins    = (pos_reg == '0) || (pos_reg > count_reg + POS_W'(1));
        sts.full       = (count_reg == POS_W'(CAPACITY));
        sts.empty      = (count_reg == '0);
        sts.append     = (pos_m1 == count_reg);
        sts.ptr_last   = (ptr_reg == cnt_addr);
        sts.ptr_at_pos = (ptr_reg == pos_addr);
        sts.tag_at_pos = (tag_reg == pos_addr);
        sts.pend       = pend_reg;
        sts.match      = pend_reg && (rdata == val_reg);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign data           = out_data_reg;
    assign found_position = out_found_reg;
    assign count          = out_count_reg;
    assign is_empty       = out_empty_reg;
endmodule

### rtl/oal_ctrl.sv
// Controller of the ordered array list engine: sequences the memory walks
// for each command. Depends on oal_pkg.
module oal_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  oal_pkg::sts_t sts,
    output oal_pkg::ctl_t ctl
);
    oal_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= oal_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        in_ready          = 1'b0;
        ctl.ld            = 1'b0;
        ctl.ptr_op        = oal_pkg::PTR_HOLD;
        ctl.rd            = 1'b0;
        ctl.wr            = oal_pkg::WR_NONE;
        ctl.cnt_op        = oal_pkg::CNT_HOLD;
        ctl.res_status_ld = 1'b0;
        ctl.res_status    = oal_pkg::STAT_DONE;
        ctl.cap_data      = 1'b0;
        ctl.set_found     = 1'b0;
        ctl.out_ld        = 1'b0;

        case (state_reg)
            oal_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.ld     = 1'b1;
                    state_next = oal_pkg::ST_DECODE;
                end
            end

            oal_pkg::ST_DECODE:
            begin
                state_next = oal_pkg::ST_FINISH;
                case (sts.cmd)
                    oal_pkg::CMD_GET:
                    begin
                        if (sts.bad_get)
                        begin
                            ctl.res_status_ld = 1'b1;
                            ctl.res_status    = oal_pkg::STAT_BADPOS;
                        end
                        else
                        begin
                            ctl.ptr_op = oal_pkg::PTR_LOAD_POSM1;
                            state_next = oal_pkg::ST_GET_RD;
                        end
                    end
                    oal_pkg::CMD_INSERT:
                    begin
                        if (sts.bad_ins)
                        begin
                            ctl.res_status_ld = 1'b1;
                            ctl.res_status    = oal_pkg::STAT_BADPOS;
                        end
                        else if (sts.full)
                        begin
                            ctl.res_status_ld = 1'b1;
                            ctl.res_status    = oal_pkg::STAT_FULL;
                        end
                        else if (sts.append)
                        begin
                            state_next = oal_pkg::ST_INS_PUT;
                        end
                        else
                        begin
                            ctl.ptr_op = oal_pkg::PTR_LOAD_CNTM1;
                            state_next = oal_pkg::ST_INS_SHIFT;
                        end
                    end
                    oal_pkg::CMD_DELETE:
                    begin
                        if (sts.bad_get)
                        begin
                            ctl.res_status_ld = 1'b1;
                            ctl.res_status    = oal_pkg::STAT_BADPOS;
                        end
                        else
                        begin
                            ctl.ptr_op = oal_pkg::PTR_LOAD_POSM1;
                            state_next = oal_pkg::ST_DEL_SHIFT;
                        end
                    end
                    oal_pkg::CMD_CHANGE:
                    begin
                        if (sts.bad_get)
                        begin
                            ctl.res_status_ld = 1'b1;
                            ctl.res_status    = oal_pkg::STAT_BADPOS;
                        end
                        else
                        begin
                            ctl.wr = oal_pkg::WR_VAL_POS;
                        end
                    end
                    oal_pkg::CMD_LOCATE:
                    begin
                        if (sts.empty)
                        begin
                            ctl.res_status_ld = 1'b1;
                            ctl.res_status    = oal_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            ctl.ptr_op = oal_pkg::PTR_LOAD_ZERO;
                            state_next = oal_pkg::ST_LOC_SCAN;
                        end
                    end
                    oal_pkg::CMD_CLEAR:
                    begin
                        ctl.cnt_op = oal_pkg::CNT_CLR;
                    end
                    default:
                    begin
                        state_next = oal_pkg::ST_FINISH;
                    end
                endcase
            end

            oal_pkg::ST_GET_RD:
            begin
                ctl.rd     = 1'b1;
                state_next = oal_pkg::ST_GET_CAP;
            end

            oal_pkg::ST_GET_CAP:
            begin
                ctl.cap_data = 1'b1;
                state_next   = oal_pkg::ST_FINISH;
            end

            // walk down from the tail; each beat of read data lands one slot up
            oal_pkg::ST_INS_SHIFT:
            begin
                ctl.rd = 1'b1;
                if (sts.pend)
                begin
                    ctl.wr = oal_pkg::WR_SHIFT_UP;
                end
                if (sts.ptr_at_pos)
                begin
                    state_next = oal_pkg::ST_INS_LAST;
                end
                else
                begin
                    ctl.ptr_op = oal_pkg::PTR_DEC;
                end
            end

            oal_pkg::ST_INS_LAST:
            begin
                ctl.wr     = oal_pkg::WR_SHIFT_UP;
                state_next = oal_pkg::ST_INS_PUT;
            end

            oal_pkg::ST_INS_PUT:
            begin
                ctl.wr     = oal_pkg::WR_VAL_POS;
                ctl.cnt_op = oal_pkg::CNT_INC;
                state_next = oal_pkg::ST_FINISH;
            end

            // walk up from the deleted slot; first read is the removed entry
            oal_pkg::ST_DEL_SHIFT:
            begin
                ctl.rd = 1'b1;
                if (sts.pend)
                begin
                    if (sts.tag_at_pos)
                    begin
                        ctl.cap_data = 1'b1;
                    end
                    else
                    begin
                        ctl.wr = oal_pkg::WR_SHIFT_DN;
                    end
                end
                if (sts.ptr_last)
                begin
                    state_next = oal_pkg::ST_DEL_LAST;
                end
                else
                begin
                    ctl.ptr_op = oal_pkg::PTR_INC;
                end
            end

            oal_pkg::ST_DEL_LAST:
            begin
                if (sts.tag_at_pos)
                begin
                    ctl.cap_data = 1'b1;
                end
                else
                begin
                    ctl.wr = oal_pkg::WR_SHIFT_DN;
                end
                ctl.cnt_op = oal_pkg::CNT_DEC;
                state_next = oal_pkg::ST_FINISH;
            end

            oal_pkg::ST_LOC_SCAN:
            begin
                if (sts.match)
                begin
                    ctl.set_found = 1'b1;
                    state_next    = oal_pkg::ST_FINISH;
                end
                else
                begin
                    ctl.rd = 1'b1;
                    if (sts.ptr_last)
                    begin
                        state_next = oal_pkg::ST_LOC_LAST;
                    end
                    else
                    begin
                        ctl.ptr_op = oal_pkg::PTR_INC;
                    end
                end
            end

            oal_pkg::ST_LOC_LAST:
            begin
                if (sts.match)
                begin
                    ctl.set_found = 1'b1;
                end
                else
                begin
                    ctl.res_status_ld = 1'b1;
                    ctl.res_status    = oal_pkg::STAT_NOTFOUND;
                end
                state_next = oal_pkg::ST_FINISH;
            end

            oal_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    ctl.out_ld = 1'b1;
                    state_next = oal_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = oal_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

### rtl/ordered_array_list_engine.sv
// Ordered array list engine: top level joining controller and datapath.
// Depends on oal_pkg, oal_if, oal_ctrl and oal_dp.
//
// Usage:
//   cmd carries one command beat (command, position, value); rsp returns
//   exactly one result beat per command (status, data, found_position,
//   count, is_empty). Positions are one-based.
//   One command is worked on at a time; cmd.ready is high only while the
//   engine is idle. The entry memory has one read and one write port, and
//   the shift and search walks move one entry per cycle through it.
//   The result sits in an output register; if the receiver stalls the next
//   command is still accepted and worked on, and it waits at the end until
//   the register frees up. Reset empties the list (length zero) at once;
//   the memory is not cleared, since only entries below the length are read.
module ordered_array_list_engine #(
    parameter int CAPACITY   = oal_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = oal_pkg::DATA_WIDTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    oal_cmd_if.sink   cmd,
    oal_rsp_if.source rsp
);
    localparam int POS_W = $clog2(CAPACITY + 2);

    oal_pkg::ctl_t ctl;
    oal_pkg::sts_t sts;

    oal_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    oal_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .POS_W      (POS_W)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sts            (sts),
        .command        (cmd.command),
        .position       (cmd.position),
        .value          (cmd.value),
        .out_ready      (rsp.ready),
        .out_valid      (rsp.valid),
        .status         (rsp.status),
        .data           (rsp.data),
        .found_position (rsp.found_position),
        .count          (rsp.count),
        .is_empty       (rsp.is_empty)
    );
endmodule

### bench/tb.sv
// Self-checking bench for the ordered array list engine: a directed table, then
// random command traffic checked against an in-bench model of the list.
// Depends on oal_pkg, oal_if and the ordered_array_list_engine RTL.
`timescale 1ns / 100ps

module tb;
    import oal_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int DATA_WIDTH   = DATA_WIDTH_DEF;
    localparam int POS_W        = 7;
    localparam int RANDOM_ITEMS = 400;
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = CAPACITY + 8;

    // codes the block accepts but does nothing with
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    typedef struct packed {
        status_t               status;
        logic [DATA_WIDTH-1:0] data;
        logic [POS_W-1:0]      found;
        logic [POS_W-1:0]      count;
        logic                  empty;
    } list_result_t;

    typedef struct {
        logic [CMD_W-1:0]      command;
        logic [POS_W-1:0]      position;
        logic [DATA_WIDTH-1:0] value;
        int                    reps;
        bit                    typed;
        list_result_t          result;
    } step_row_t;

    typedef enum {TRAFFIC_MIXED, TRAFFIC_GROW, TRAFFIC_DRAIN} traffic_t;

    logic clk = 1'b0;
    logic rst_n;

    oal_cmd_if #(.POS_W(POS_W), .DATA_W(DATA_WIDTH)) cmd_ch ();
    oal_rsp_if #(.POS_W(POS_W), .DATA_W(DATA_WIDTH)) rsp_ch ();

    ordered_array_list_engine #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // shadow copy of the list
    logic [DATA_WIDTH-1:0] list_mem [CAPACITY];
    int                    list_len;
    int                    peak_len;

    list_result_t pending_results [$];
    step_row_t    script [$];

    int mismatches      = 0;
    int directed_sent;
    int random_sent;
    int results_seen    = 0;
    int status_seen [5] = '{default: 0};
    int quiet_cycles    = 0;
    int tx_calm;
    int rx_calm         = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic list_result_t apply_command(input logic [CMD_W-1:0] c,
                                                   input logic [POS_W-1:0] p,
                                                   input logic [DATA_WIDTH-1:0] v);
        list_result_t r;
        int           pos;
        int           k;
        r   = '0;
        pos = p;
        r.status = STAT_DONE;
        case (c)
            CMD_GET:
                if (pos < 1 || pos > list_len)
                    r.status = STAT_BADPOS;
                else
                    r.data = list_mem[pos-1];
            CMD_INSERT:
                if (pos < 1 || pos > list_len + 1)
                    r.status = STAT_BADPOS;
                else if (list_len >= CAPACITY)
                    r.status = STAT_FULL;
                else
                begin
                    for (k = list_len; k > pos - 1; k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[pos-1] = v;
                    list_len++;
                end
            CMD_DELETE:
                if (pos < 1 || pos > list_len)
                    r.status = STAT_BADPOS;
                else
                begin
                    r.data = list_mem[pos-1];
                    for (k = pos; k < list_len; k++)
                        list_mem[k-1] = list_mem[k];
                    list_len--;
                end
            CMD_CHANGE:
                if (pos < 1 || pos > list_len)
                    r.status = STAT_BADPOS;
                else
                    list_mem[pos-1] = v;
            CMD_LOCATE:
                if (list_len == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    r.status = STAT_NOTFOUND;
                    for (k = 0; k < list_len; k++)
                    begin
                        if (list_mem[k] == v)
                        begin
                            r.found  = POS_W'(k + 1);
                            r.status = STAT_DONE;
                            break;
                        end
                    end
                end
            CMD_CLEAR:
                list_len = 0;
            default: ;
        endcase
        r.count = POS_W'(list_len);
        r.empty = (list_len == 0);
        return r;
    endfunction

    // mostly back-to-back or short gaps, a few long ones, and calm stretches
    function automatic int pick_gap(ref int calm_left);
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // entered and left at a falling edge
    task automatic send_command(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                                input logic [DATA_WIDTH-1:0] v, input bit typed,
                                input list_result_t typed_res);
        list_result_t r;
        int           gap;
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            cmd_ch.valid    <= 1'b0;
            cmd_ch.command  <= CMD_W'($urandom_range(0, 7));
            cmd_ch.position <= POS_W'($urandom_range(0, 127));
            cmd_ch.value    <= DATA_WIDTH'($urandom);
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.command  <= c;
        cmd_ch.position <= p;
        cmd_ch.value    <= v;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        r = apply_command(c, p, v);
        pending_results.push_back(typed ? typed_res : r);
        if (list_len > peak_len)
            peak_len = list_len;
        @(negedge clk);
    endtask

    task automatic add_checked(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                               input logic [DATA_WIDTH-1:0] v, input status_t st,
                               input logic [DATA_WIDTH-1:0] d, input logic [POS_W-1:0] f,
                               input logic [POS_W-1:0] n);
        step_row_t row;
        row.command  = c;
        row.position = p;
        row.value    = v;
        row.reps     = 1;
        row.typed    = 1'b1;
        row.result   = '{st, d, f, n, (n == 0)};
        script.push_back(row);
    endtask

    task automatic add_open(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                            input logic [DATA_WIDTH-1:0] v, input int reps);
        step_row_t row;
        row.command  = c;
        row.position = p;
        row.value    = v;
        row.reps     = reps;
        row.typed    = 1'b0;
        row.result   = '0;
        script.push_back(row);
    endtask

    function automatic logic [DATA_WIDTH-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return DATA_WIDTH'($urandom_range(0, 3));    // duplicates make first-match matter
        if (r < 30)
            return '1;
        return DATA_WIDTH'($urandom);
    endfunction

    task automatic random_item(input traffic_t mode);
        logic [CMD_W-1:0]      c;
        logic [POS_W-1:0]      p;
        logic [DATA_WIDTH-1:0] v;
        int                    ins_w;
        int                    del_w;
        int                    r;
        int                    hi;
        ins_w = (mode == TRAFFIC_GROW) ? 70 : (mode == TRAFFIC_DRAIN) ? 5 : 30;
        del_w = (mode == TRAFFIC_GROW) ? 5 : (mode == TRAFFIC_DRAIN) ? 70 : 20;
        r = $urandom_range(0, 99);
        if (r < ins_w)
            c = CMD_INSERT;
        else if (r < ins_w + del_w)
            c = CMD_DELETE;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                c = CMD_GET;
            else if (r < 50)
                c = CMD_CHANGE;
            else if (r < 80)
                c = CMD_LOCATE;
            else if (r < 84)
                c = CMD_SPARE6;
            else if (r < 88)
                c = CMD_SPARE7;
            else if (r < 92 && mode == TRAFFIC_MIXED)
                c = CMD_CLEAR;
            else
                c = CMD_LOCATE;
        end
        hi = (c == CMD_INSERT) ? list_len + 1 : list_len;
        r  = $urandom_range(0, 99);
        if (hi >= 1 && r < 8)
            p = ($urandom_range(0, 1) != 0) ? POS_W'(1) : POS_W'(hi);
        else if (hi >= 1 && r < 85)
            p = POS_W'($urandom_range(1, hi));
        else
            p = POS_W'($urandom_range(0, 127));
        if (c == CMD_LOCATE && list_len > 0 && $urandom_range(0, 99) < 60)
            v = list_mem[$urandom_range(0, list_len - 1)];
        else
            v = pick_value();
        send_command(c, p, v, 1'b0, '0);
        random_sent++;
    endtask

    // result side: random stalls on ready
    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            stall = pick_gap(rx_calm);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (rsp_ch.status < 5)
                status_seen[rsp_ch.status]++;
            if (pending_results.size() == 0)
            begin
                $error("result beat with no command outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    mismatches++;
                end
                if (rsp_ch.data !== want.data)
                begin
                    $error("data: expected %h, got %h", want.data, rsp_ch.data);
                    mismatches++;
                end
                if (rsp_ch.found_position !== want.found)
                begin
                    $error("found_position: expected %0d, got %0d",
                           want.found, rsp_ch.found_position);
                    mismatches++;
                end
                if (rsp_ch.count !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, rsp_ch.count);
                    mismatches++;
                end
                if (rsp_ch.is_empty !== want.empty)
                begin
                    $error("is_empty: expected %0d, got %0d", want.empty, rsp_ch.is_empty);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: too long without any beat on either channel
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int i;
        int n;
        rst_n           = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.command  = '0;
        cmd_ch.position = '0;
        cmd_ch.value    = '0;
        list_len        = 0;
        peak_len        = 0;
        directed_sent   = 0;
        random_sent     = 0;
        tx_calm         = 0;

        // empty-list errors, then a small list with duplicates
        add_checked(CMD_LOCATE, 0, 32'h0, STAT_EMPTY, 0, 0, 0);
        add_checked(CMD_GET, 1, 32'h0, STAT_BADPOS, 0, 0, 0);
        add_checked(CMD_DELETE, 1, 32'h0, STAT_BADPOS, 0, 0, 0);
        add_checked(CMD_CHANGE, 1, 32'h1, STAT_BADPOS, 0, 0, 0);
        add_checked(CMD_INSERT, 0, 32'h1, STAT_BADPOS, 0, 0, 0);
        add_checked(CMD_INSERT, 2, 32'h1, STAT_BADPOS, 0, 0, 0);
        add_checked(CMD_INSERT, 1, 32'hFFFF_FFFF, STAT_DONE, 0, 0, 1);
        add_checked(CMD_INSERT, 1, 32'h0, STAT_DONE, 0, 0, 2);
        add_checked(CMD_INSERT, 3, 32'h5A5A_5A5A, STAT_DONE, 0, 0, 3);
        add_checked(CMD_INSERT, 2, 32'h0, STAT_DONE, 0, 0, 4);
        add_checked(CMD_LOCATE, 0, 32'h0, STAT_DONE, 0, 1, 4);
        add_checked(CMD_LOCATE, 0, 32'hFFFF_FFFF, STAT_DONE, 0, 3, 4);
        add_checked(CMD_LOCATE, 0, 32'h1234_5678, STAT_NOTFOUND, 0, 0, 4);
        add_checked(CMD_GET, 4, 32'h0, STAT_DONE, 32'h5A5A_5A5A, 0, 4);
        add_checked(CMD_GET, 5, 32'h0, STAT_BADPOS, 0, 0, 4);
        add_checked(CMD_CHANGE, 4, 32'hA5A5_A5A5, STAT_DONE, 0, 0, 4);
        add_checked(CMD_GET, 127, 32'h0, STAT_BADPOS, 0, 0, 4);
        add_checked(CMD_DELETE, 1, 32'h0, STAT_DONE, 32'h0, 0, 3);
        add_checked(CMD_DELETE, 3, 32'h0, STAT_DONE, 32'hA5A5_A5A5, 0, 2);
        add_checked(CMD_SPARE6, 1, 32'h1234, STAT_DONE, 0, 0, 2);
        add_checked(CMD_SPARE7, 2, 32'hFFFF_FFFF, STAT_DONE, 0, 0, 2);
        add_checked(CMD_CLEAR, 0, 32'h0, STAT_DONE, 0, 0, 0);
        add_checked(CMD_INSERT, 1, 32'h8000_0001, STAT_DONE, 0, 0, 1);
        add_checked(CMD_DELETE, 64, 32'h0, STAT_BADPOS, 0, 0, 1);
        add_checked(CMD_DELETE, 1, 32'h0, STAT_DONE, 32'h8000_0001, 0, 0);
        // fill from the front (longest shifts), then hit the full list
        add_open(CMD_INSERT, 1, 32'h100, CAPACITY);
        add_checked(CMD_INSERT, POS_W'(CAPACITY + 1), 32'h0, STAT_FULL, 0, 0,
                    POS_W'(CAPACITY));
        add_checked(CMD_INSERT, POS_W'(CAPACITY + 2), 32'h0, STAT_BADPOS, 0, 0,
                    POS_W'(CAPACITY));
        add_checked(CMD_LOCATE, 0, 32'h100, STAT_DONE, 0, POS_W'(CAPACITY),
                    POS_W'(CAPACITY));
        add_checked(CMD_GET, POS_W'(CAPACITY), 32'h0, STAT_DONE, 32'h100, 0,
                    POS_W'(CAPACITY));
        add_checked(CMD_GET, 1, 32'h0, STAT_DONE, 32'h100 + CAPACITY - 1, 0,
                    POS_W'(CAPACITY));
        add_checked(CMD_DELETE, POS_W'(CAPACITY), 32'h0, STAT_DONE, 32'h100, 0,
                    POS_W'(CAPACITY - 1));
        add_checked(CMD_CHANGE, 0, 32'h0, STAT_BADPOS, 0, 0, POS_W'(CAPACITY - 1));
        add_checked(CMD_CLEAR, 5, 32'h0, STAT_DONE, 0, 0, 0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[r])
        begin
            for (i = 0; i < script[r].reps; i++)
            begin
                send_command(script[r].command, script[r].position,
                             script[r].value + i, script[r].typed, script[r].result);
                directed_sent++;
            end
        end

        for (n = 0; n < 100; n++)
            random_item(TRAFFIC_MIXED);
        while (list_len < CAPACITY)
            random_item(TRAFFIC_GROW);
        for (n = 0; n < 12; n++)
            random_item(TRAFFIC_GROW);

        // hold off until the block has drained every outstanding result
        cmd_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);

        while (list_len > 0)
            random_item(TRAFFIC_DRAIN);
        for (n = 0; n < 4; n++)
            random_item(TRAFFIC_DRAIN);
        while (random_sent < RANDOM_ITEMS)
            random_item(TRAFFIC_MIXED);
        cmd_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d directed and %0d random commands, checked %0d results;",
                 directed_sent, random_sent, results_seen);
        $display("list grew to %0d of %0d entries; statuses seen: done %0d, bad position %0d,",
                 peak_len, CAPACITY, status_seen[0], status_seen[1]);
        $display("full %0d, not found %0d, empty %0d.",
                 status_seen[2], status_seen[3], status_seen[4]);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
rtl/oal_pkg.sv
rtl/oal_if.sv
rtl/oal_ram.sv
rtl/oal_dp.sv
rtl/oal_ctrl.sv
rtl/ordered_array_list_engine.sv
bench/tb.sv
